[rtl/button_press_classifier_defines.svh]
// ----------------------------------------------------------------------------
// Button press classifier assertion macros
// Shared property shorthands for the port checker.
// ----------------------------------------------------------------------------
`ifndef BUTTON_PRESS_CLASSIFIER_DEFINES_SVH
`define BUTTON_PRESS_CLASSIFIER_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BPC_ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BPC_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/bpc_pkg.sv]
// ----------------------------------------------------------------------------
// Button press classifier package
// Widths, timing constants, register indexes and shared types.
// ----------------------------------------------------------------------------
package bpc_pkg;

    localparam int AVG_LENGTH  = 4;
    localparam int TIME_W      = 32;
    localparam int OVER_W      = 16;
    localparam int REPEAT_W    = 10;
    localparam int STATUS_W    = 2;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_TDATA_W = 8;
    localparam int CFG_ADDR_W  = 1;
    localparam int CFG_DATA_W  = 16;

    localparam int unsigned CHECK_PERIOD_MS = 20;
    localparam int unsigned LONG_PRESS_MS   = 1500;
    localparam int unsigned TRIGGER_ON      = 100;
    localparam int unsigned TRIGGER_OFF     = 50;
    localparam int unsigned SAMPLE_HIGH     = 200;

    localparam logic [OVER_W-1:0]   OVER_PRESS_RESET = OVER_W'(2500);
    localparam logic [REPEAT_W-1:0] REPEAT_RESET     = '0;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_OVER_PRESS = 1'b0,
        CFG_REPEAT     = 1'b1
    } t_cfg_reg;

    typedef enum logic [STATUS_W-1:0] {
        ST_NONE  = 2'd0,
        ST_SHORT = 2'd1,
        ST_LONG  = 2'd2
    } t_status;

    typedef struct packed {
        logic [OVER_W-1:0]   over_press_ms;
        logic [REPEAT_W-1:0] repeat_period_ms;
    } t_press_cfg;

endpackage

[rtl/bpc_debounce.sv]
// ----------------------------------------------------------------------------
// Button press classifier debouncer
// Rounded exponential average of the pin samples with on/off hysteresis.
// ----------------------------------------------------------------------------
module bpc_debounce #(
    parameter int AVG_LENGTH = bpc_pkg::AVG_LENGTH
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_sample_en,
    input  logic i_pin,
    output logic o_on_next
);

    localparam int ACC_W       = $clog2(201 * AVG_LENGTH + 1);
    localparam int RND_W       = ACC_W + 1;
    localparam int RECIP_SHIFT = 24;
    localparam int RECIP_W     = RECIP_SHIFT + 1;
    localparam int PROD_W      = RND_W + RECIP_W;
    localparam logic [RECIP_W-1:0] RECIP =
        RECIP_W'(((1 << RECIP_SHIFT) + AVG_LENGTH - 1) / AVG_LENGTH);
    localparam logic [RND_W-1:0] HALF = RND_W'(AVG_LENGTH / 2);

    logic [ACC_W-1:0]  r_acc;
    logic [ACC_W-1:0]  r_avg;
    logic              r_on;
    logic [ACC_W-1:0]  n_acc;
    logic [ACC_W-1:0]  w_sample;
    logic [RND_W-1:0]  w_round;
    logic [PROD_W-1:0] w_prod;
    logic [ACC_W-1:0]  n_avg;

    // The stored average equals the rounded quotient of the stored accumulator.
    assign w_sample = i_pin ? ACC_W'(bpc_pkg::SAMPLE_HIGH) : '0;
    assign n_acc    = r_acc + w_sample - r_avg;
    assign w_round  = {1'b0, n_acc} + HALF;
    assign w_prod   = PROD_W'(w_round) * PROD_W'(RECIP);
    assign n_avg    = w_prod[RECIP_SHIFT +: ACC_W];

    always_comb begin
        if (r_on) begin
            o_on_next = !(n_avg < ACC_W'(bpc_pkg::TRIGGER_OFF));
        end else begin
            o_on_next = n_avg > ACC_W'(bpc_pkg::TRIGGER_ON);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc <= '0;
            r_avg <= '0;
            r_on  <= 1'b0;
        end else if (i_sample_en) begin
            r_acc <= n_acc;
            r_avg <= n_avg;
            r_on  <= o_on_next;
        end
    end

endmodule

[rtl/bpc_press.sv]
// ----------------------------------------------------------------------------
// Button press classifier press timer
// Check pacing, press timing and short, long and repeat classification.
// ----------------------------------------------------------------------------
module bpc_press (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_advance,
    input  logic [bpc_pkg::TIME_W-1:0]    i_now,
    input  logic                          i_on_next,
    input  bpc_pkg::t_press_cfg           i_cfg,
    output logic                          o_check,
    output bpc_pkg::t_status              o_status
);

    localparam int TW = bpc_pkg::TIME_W;

    logic [TW-1:0] r_next_check;
    logic [TW-1:0] r_start;
    logic          r_long_done;
    logic [TW-1:0] r_last_rep;
    logic [TW-1:0] n_next_check;
    logic [TW-1:0] n_start;
    logic          n_long_done;
    logic [TW-1:0] n_last_rep;
    logic [TW-1:0] w_held;
    logic [TW-1:0] w_since_rep;
    logic [TW-1:0] w_over;
    logic [TW-1:0] w_repeat;
    logic          w_no_press;

    assign o_check     = !(i_now < r_next_check);
    assign w_held      = i_now - r_start;
    assign w_since_rep = i_now - r_last_rep;
    assign w_over      = TW'(i_cfg.over_press_ms);
    assign w_repeat    = TW'(i_cfg.repeat_period_ms);
    assign w_no_press  = r_start == '0;

    always_comb begin
        n_next_check = r_next_check;
        n_start      = r_start;
        n_long_done  = r_long_done;
        n_last_rep   = r_last_rep;
        o_status     = bpc_pkg::ST_NONE;
        if (o_check) begin
            n_next_check = i_now + TW'(bpc_pkg::CHECK_PERIOD_MS);
            if (i_on_next) begin
                if (w_no_press || w_held > w_over) begin
                    n_start = i_now;
                end else if (w_held > TW'(bpc_pkg::LONG_PRESS_MS) && !r_long_done) begin
                    if (w_repeat != '0) begin
                        if (w_since_rep > w_repeat) begin
                            n_last_rep = i_now;
                            o_status   = bpc_pkg::ST_SHORT;
                        end
                    end else begin
                        n_long_done = 1'b1;
                        o_status    = bpc_pkg::ST_LONG;
                    end
                end
            end else begin
                n_start     = '0;
                n_long_done = 1'b0;
                if (!w_no_press && !r_long_done && w_held < w_over) begin
                    o_status = bpc_pkg::ST_SHORT;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_next_check <= '0;
            r_start      <= '0;
            r_long_done  <= 1'b0;
            r_last_rep   <= '0;
        end else if (i_advance) begin
            r_next_check <= n_next_check;
            r_start      <= n_start;
            r_long_done  <= n_long_done;
            r_last_rep   <= n_last_rep;
        end
    end

endmodule

[rtl/button_press_classifier.sv]
// Path: an accepted beat is held in the input register, then its result in the result register.
// Throughput: one beat per cycle; the input register refills while the result
// register drains; back-pressure stalls the result stage and a held input beat.
// All classification state sits in single registers updated only as beats advance.
// Reset (synchronous, active low) empties both stages, clears all press state
// and restores over_press_ms to 2500 and repeat_period_ms to 0.
// ----------------------------------------------------------------------------
// Button press classifier
// Debounces a sampled push button and reports short, long and repeat presses.
// ----------------------------------------------------------------------------
module button_press_classifier #(
    parameter int AVG_LENGTH = bpc_pkg::AVG_LENGTH
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_tvalid,
    output logic                               o_s_tready,
    // now_ms [31:0], pin_high [32], zero fill [39:33]
    input  logic [bpc_pkg::IN_TDATA_W-1:0]     i_s_tdata,
    output logic                               o_m_tvalid,
    input  logic                               i_m_tready,
    // press_status [1:0], zero fill [7:2]
    output logic [bpc_pkg::OUT_TDATA_W-1:0]    o_m_tdata,
    input  logic                               i_cfg_we,
    input  logic [bpc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  logic [bpc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    localparam int TW = bpc_pkg::TIME_W;

    logic                r_in_valid;
    logic [TW-1:0]       r_in_now;
    logic                r_in_pin;
    logic                r_out_valid;
    bpc_pkg::t_status    r_out_status;
    bpc_pkg::t_press_cfg r_cfg;
    logic                w_out_free;
    logic                w_advance;
    logic                w_check;
    logic                w_on_next;
    bpc_pkg::t_status    w_status;

    assign w_out_free = !r_out_valid || i_m_tready;
    assign w_advance  = r_in_valid && w_out_free;
    assign o_s_tready = !r_in_valid || w_out_free;
    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = bpc_pkg::OUT_TDATA_W'(r_out_status);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid          <= 1'b0;
            r_out_valid         <= 1'b0;
            r_cfg.over_press_ms <= bpc_pkg::OVER_PRESS_RESET;
            r_cfg.repeat_period_ms <= bpc_pkg::REPEAT_RESET;
        end else begin
            if (o_s_tready) begin
                r_in_valid <= i_s_tvalid;
            end
            if (w_out_free) begin
                r_out_valid <= r_in_valid;
            end
            if (i_cfg_we) begin
                case (bpc_pkg::t_cfg_reg'(i_cfg_addr))
                    bpc_pkg::CFG_OVER_PRESS: begin
                        r_cfg.over_press_ms <= i_cfg_wdata[bpc_pkg::OVER_W-1:0];
                    end
                    bpc_pkg::CFG_REPEAT: begin
                        r_cfg.repeat_period_ms <= i_cfg_wdata[bpc_pkg::REPEAT_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_s_tready && i_s_tvalid) begin
            r_in_now <= i_s_tdata[TW-1:0];
            r_in_pin <= i_s_tdata[TW];
        end
        if (w_advance) begin
            r_out_status <= w_status;
        end
    end

    bpc_debounce #(
        .AVG_LENGTH (AVG_LENGTH)
    ) u_debounce (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_sample_en (w_advance && w_check),
        .i_pin       (r_in_pin),
        .o_on_next   (w_on_next)
    );

    bpc_press u_press (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_advance),
        .i_now     (r_in_now),
        .i_on_next (w_on_next),
        .i_cfg     (r_cfg),
        .o_check   (w_check),
        .o_status  (w_status)
    );

endmodule

[rtl/bpc_checker.sv]
// ----------------------------------------------------------------------------
// Button press classifier port checker
// Watches the stream ports of the classifier and is bound to its top level.
// ----------------------------------------------------------------------------
`include "button_press_classifier_defines.svh"

module bpc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_tready,
    input logic                            o_m_tvalid,
    input logic                            i_m_tready,
    input logic [bpc_pkg::OUT_TDATA_W-1:0] o_m_tdata
);

    `BPC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "Stalled result beat changed.")
    `BPC_ASSERT_SAME(a_ready_when_empty, i_clk, i_rst_n, !o_m_tvalid, o_s_tready, "Input stalled with an empty result stage.")
    `BPC_ASSERT_SAME(a_ready_when_drain, i_clk, i_rst_n, i_m_tready, o_s_tready, "Input stalled while results drain.")
    `BPC_ASSERT_SAME(a_status_code, i_clk, i_rst_n, o_m_tvalid, o_m_tdata[bpc_pkg::OUT_TDATA_W-1:2] == '0 && o_m_tdata[1:0] != 2'b11, "Result beat holds an unknown status.")

endmodule

bind button_press_classifier bpc_checker u_bpc_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
